/* sv/rrpg_pkg.sv */
// shared types and constants of the range reading plausibility gate
// no dependencies

package rrpg_pkg;

  localparam int TimeBits = 32;
  localparam int DistW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int ProdW    = DistW + TimeBits;
  localparam int DiffKW   = 26;
  localparam int QuotW    = 15;
  localparam int DivSteps = QuotW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [TimeBits-1:0] MinDtMs    = TimeBits'(20);
  localparam logic [DiffKW-1:0]   MsPerS     = DiffKW'(1000);
  localparam logic [15:0]         GapSat     = 16'hFFFF;
  localparam logic [15:0]         OneQ15     = 16'h8000;
  localparam logic [7:0]          RstatClear = 8'hFF;
  localparam logic                FuncClear  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSensorEnabled = 3'd0,
    CfgRecentValid   = 3'd1,
    CfgValidMin      = 3'd2,
    CfgValidMax      = 3'd3,
    CfgStepFloor     = 3'd4,
    CfgStepRate      = 3'd5,
    CfgBlendFull     = 3'd6,
    CfgBlendZero     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RejNone     = 3'd0,
    RejDisabled = 3'd1,
    RejNoData   = 3'd2,
    RejTimeout  = 3'd3,
    RejTooFar   = 3'd4,
    RejJump     = 3'd5
  } reject_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic eval;
    logic div_step;
    logic load_out;
  } rrpg_cmd_t;

  typedef struct packed {
    logic need_div;
  } rrpg_status_t;

endpackage

/* sv/rrpg_ctrl.sv */
// controller state machine of the range reading plausibility gate
// depends on rrpg_pkg

module rrpg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rrpg_pkg::rrpg_status_t status_i,
  output rrpg_pkg::rrpg_cmd_t    cmd_o
);
  import rrpg_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StEval = 5'b00100,
    StDiv  = 5'b01000,
    StOut  = 5'b10000
  } ctrl_state_e;

  ctrl_state_e          state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StEval;
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        cnt_d      = '0;
        state_d    = status_i.need_div ? StDiv : StOut;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/rrpg_datapath.sv */
// datapath of the range reading plausibility gate: settings, filter state,
// jump test, blend weight divider and output register; depends on rrpg_pkg

module rrpg_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rrpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           func_i,
  input  logic [31:0]                    time_ms_i,
  input  logic                           data_ready_i,
  input  logic                           timed_out_i,
  input  logic [15:0]                    distance_mm_i,
  input  logic [7:0]                     meas_status_i,
  input  logic [7:0]                     bus_status_i,
  input  rrpg_pkg::rrpg_cmd_t             cmd_i,
  output rrpg_pkg::rrpg_status_t          status_o,
  output logic [15:0]                    altitude_mm_o,
  output logic                           altitude_valid_o,
  output logic                           fresh_ok_o,
  output logic [2:0]                     reject_reason_o,
  output logic [15:0]                    attempt_gap_ms_o,
  output logic [15:0]                    raw_mm_o,
  output logic [7:0]                     last_meas_status_o,
  output logic [7:0]                     last_bus_status_o,
  output logic [15:0]                    blend_weight_o
);
  import rrpg_pkg::*;

  // settings
  logic          en_q;
  logic [15:0]   recent_q, vmin_q, vmax_q, floor_q, rate_q, full_q, zero_q;

  // filter state
  logic [15:0]          good_q, raw_q;
  logic [TimeBits-1:0]  good_time_q, prev_q;
  logic                 have_good_q, have_att_q;
  logic [7:0]           rstat_reg_q;

  // captured transaction
  logic                 func_q, rdy_q, tout_q;
  logic [TimeBits-1:0]  now_q;
  logic [15:0]          dist_q;
  logic [7:0]           rstat_q, bstat_q;

  // first stage
  logic [15:0]          m_q, diff_q;
  logic [DiffKW-1:0]    diff_k_q;
  logic [ProdW-1:0]     prod_q;

  // pending result
  logic [15:0]          res_alt_q, res_gap_q, res_weight_q;
  logic                 res_valid_q, res_fresh_q, res_use_div_q;
  reject_e              res_reason_q;
  logic [7:0]           res_bstat_q;

  // divider
  logic [15:0]          rem_q, den_q;
  logic [QuotW-1:0]     quot_q;

  // output register
  logic [15:0]          o_alt_q, o_gap_q, o_raw_q, o_weight_q;
  logic                 o_valid_q, o_fresh_q;
  reject_e              o_reason_q;
  logic [7:0]           o_rstat_q, o_bstat_q;

  logic [15:0]          m_c, diff_c;
  logic [TimeBits-1:0]  age_c, dt_c, gap_raw_c;
  logic [15:0]          gap_sat_c;
  logic                 jump_c;

  logic [15:0]          alt_c, weight_c, gap_c;
  logic [7:0]           bstat_c;
  logic                 valid_c, fresh_c, clear_c, upd_good_c, upd_raw_c, upd_rstat_c;
  logic                 w_full_c, w_zero_c, need_div_c;
  reject_e              reason_c;

  logic [16:0]          rem2_c;
  logic                 ge_c;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      recent_q <= 16'd100;
      vmin_q   <= 16'd40;
      vmax_q   <= 16'd4000;
      floor_q  <= 16'd300;
      rate_q   <= 16'd3000;
      full_q   <= 16'd1000;
      zero_q   <= 16'd2000;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSensorEnabled: en_q     <= cfg_wdata_i[0];
        CfgRecentValid:   recent_q <= cfg_wdata_i;
        CfgValidMin:      vmin_q   <= cfg_wdata_i;
        CfgValidMax:      vmax_q   <= cfg_wdata_i;
        CfgStepFloor:     floor_q  <= cfg_wdata_i;
        CfgStepRate:      rate_q   <= cfg_wdata_i;
        CfgBlendFull:     full_q   <= cfg_wdata_i;
        CfgBlendZero:     zero_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // first stage arithmetic
  assign m_c    = (dist_q < vmin_q) ? 16'd0 : dist_q;
  assign diff_c = (m_c > good_q) ? (m_c - good_q) : (good_q - m_c);
  assign age_c  = now_q - good_time_q;
  assign dt_c   = (age_c < MinDtMs) ? MinDtMs : age_c;

  // evaluation
  assign gap_raw_c = now_q - prev_q;
  assign gap_sat_c = (|gap_raw_c[TimeBits-1:16]) ? GapSat : gap_raw_c[15:0];
  assign jump_c    = (diff_q > floor_q) && (ProdW'(diff_k_q) > prod_q);

  always_comb begin
    alt_c       = '0;
    valid_c     = 1'b0;
    fresh_c     = 1'b0;
    reason_c    = RejNone;
    gap_c       = '0;
    bstat_c     = bstat_q;
    clear_c     = 1'b0;
    upd_good_c  = 1'b0;
    upd_raw_c   = 1'b0;
    upd_rstat_c = 1'b0;
    if (func_q == FuncClear) begin
      clear_c = 1'b1;
      bstat_c = '0;
    end else begin
      gap_c = have_att_q ? gap_sat_c : 16'd0;
      if (!en_q) begin
        reason_c = RejDisabled;
      end else if (!rdy_q) begin
        reason_c = RejNoData;
        if (have_good_q && (age_c <= TimeBits'(recent_q))) begin
          alt_c   = good_q;
          valid_c = 1'b1;
        end
      end else begin
        upd_rstat_c = 1'b1;
        if (tout_q) begin
          reason_c = RejTimeout;
        end else begin
          upd_raw_c = 1'b1;
          if (dist_q > vmax_q) begin
            reason_c = RejTooFar;
          end else if (have_good_q && jump_c) begin
            reason_c = RejJump;
          end else begin
            upd_good_c = 1'b1;
            alt_c      = m_q;
            valid_c    = 1'b1;
            fresh_c    = 1'b1;
          end
        end
      end
    end
  end

  assign w_full_c   = (alt_c <= full_q);
  assign w_zero_c   = (alt_c >= zero_q);
  assign need_div_c = valid_c && !w_full_c && !w_zero_c;
  assign weight_c   = (valid_c && w_full_c) ? OneQ15 : 16'd0;

  assign status_o.need_div = need_div_c;

  // restoring divider, one quotient bit per step
  assign rem2_c = {rem_q, 1'b0};
  assign ge_c   = (rem2_c >= {1'b0, den_q});

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      good_time_q <= '0;
      have_good_q <= 1'b0;
      prev_q      <= '0;
      have_att_q  <= 1'b0;
      raw_q       <= '0;
      rstat_reg_q <= RstatClear;
    end else if (cmd_i.eval) begin
      if (clear_c) begin
        good_q      <= '0;
        good_time_q <= '0;
        have_good_q <= 1'b0;
        raw_q       <= '0;
        rstat_reg_q <= RstatClear;
      end else begin
        prev_q     <= now_q;
        have_att_q <= 1'b1;
        if (upd_rstat_c) begin
          rstat_reg_q <= rstat_q;
        end
        if (upd_raw_c) begin
          raw_q <= dist_q;
        end
        if (upd_good_c) begin
          good_q      <= m_q;
          good_time_q <= now_q;
          have_good_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      now_q   <= time_ms_i[TimeBits-1:0];
      rdy_q   <= data_ready_i;
      tout_q  <= timed_out_i;
      dist_q  <= distance_mm_i;
      rstat_q <= meas_status_i;
      bstat_q <= bus_status_i;
    end
    if (cmd_i.mul) begin
      m_q      <= m_c;
      diff_q   <= diff_c;
      diff_k_q <= DiffKW'(diff_c) * MsPerS;
      prod_q   <= ProdW'(rate_q) * ProdW'(dt_c);
    end
    if (cmd_i.eval) begin
      res_alt_q     <= alt_c;
      res_valid_q   <= valid_c;
      res_fresh_q   <= fresh_c;
      res_reason_q  <= reason_c;
      res_gap_q     <= gap_c;
      res_bstat_q   <= bstat_c;
      res_weight_q  <= weight_c;
      res_use_div_q <= need_div_c;
      rem_q         <= zero_q - alt_c;
      den_q         <= zero_q - full_q;
      quot_q        <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge_c ? 16'(rem2_c - {1'b0, den_q}) : rem2_c[15:0];
      quot_q <= {quot_q[QuotW-2:0], ge_c};
    end
    if (cmd_i.load_out) begin
      o_alt_q    <= res_alt_q;
      o_valid_q  <= res_valid_q;
      o_fresh_q  <= res_fresh_q;
      o_reason_q <= res_reason_q;
      o_gap_q    <= res_gap_q;
      o_raw_q    <= raw_q;
      o_rstat_q  <= rstat_reg_q;
      o_bstat_q  <= res_bstat_q;
      o_weight_q <= res_use_div_q ? {1'b0, quot_q} : res_weight_q;
    end
  end

  assign altitude_mm_o      = o_alt_q;
  assign altitude_valid_o   = o_valid_q;
  assign fresh_ok_o         = o_fresh_q;
  assign reject_reason_o    = o_reason_q;
  assign attempt_gap_ms_o   = o_gap_q;
  assign raw_mm_o           = o_raw_q;
  assign last_meas_status_o = o_rstat_q;
  assign last_bus_status_o  = o_bstat_q;
  assign blend_weight_o     = o_weight_q;

endmodule

/* sv/range_reading_plausibility_gate_unit.sv */
// top level of the range reading plausibility gate
// depends on rrpg_pkg, rrpg_ctrl and rrpg_datapath
//
// One transaction in gives one transaction out. After acceptance the result passes the
// multiply and evaluate states and is loaded into the output register in the output
// state. When the altitude lies strictly between the two blend heights, the weight
// first goes through a restoring divider in the divide state that yields one quotient
// bit per cycle. A new transaction is taken the cycle after the previous one has
// reached the output register, even if that result is still waiting for out_ready_i;
// a result held back by out_ready_i stalls the following one in its output state.
// Timestamps are 32 bits and every time difference wraps modulo 2^32. Settings may be
// written only while no transaction is in flight.

module range_reading_plausibility_gate_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rrpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [31:0]                    time_ms_i,
  input  logic                           data_ready_i,
  input  logic                           timed_out_i,
  input  logic [15:0]                    distance_mm_i,
  input  logic [7:0]                     meas_status_i,
  input  logic [7:0]                     bus_status_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [15:0]                    altitude_mm_o,
  output logic                           altitude_valid_o,
  output logic                           fresh_ok_o,
  output logic [2:0]                     reject_reason_o,
  output logic [15:0]                    attempt_gap_ms_o,
  output logic [15:0]                    raw_mm_o,
  output logic [7:0]                     last_meas_status_o,
  output logic [7:0]                     last_bus_status_o,
  output logic [15:0]                    blend_weight_o
);
  import rrpg_pkg::*;

  rrpg_cmd_t    cmd;
  rrpg_status_t status;

  rrpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rrpg_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .func_i             (func_i),
    .time_ms_i          (time_ms_i),
    .data_ready_i       (data_ready_i),
    .timed_out_i        (timed_out_i),
    .distance_mm_i      (distance_mm_i),
    .meas_status_i      (meas_status_i),
    .bus_status_i       (bus_status_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .altitude_mm_o      (altitude_mm_o),
    .altitude_valid_o   (altitude_valid_o),
    .fresh_ok_o         (fresh_ok_o),
    .reject_reason_o    (reject_reason_o),
    .attempt_gap_ms_o   (attempt_gap_ms_o),
    .raw_mm_o           (raw_mm_o),
    .last_meas_status_o (last_meas_status_o),
    .last_bus_status_o  (last_bus_status_o),
    .blend_weight_o     (blend_weight_o)
  );

endmodule

/* sv/rrpg_checker.sv */
// port-level checks of the range reading plausibility gate, bound to the top level
// depends on rrpg_pkg and range_reading_plausibility_gate_unit

module rrpg_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [15:0]                    altitude_mm_o,
  input  logic                           altitude_valid_o,
  input  logic                           fresh_ok_o,
  input  logic [2:0]                     reject_reason_o,
  input  logic [15:0]                    blend_weight_o
);
  import rrpg_pkg::*;

  // a pending result is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction");

  // one transaction at a time in the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on consecutive cycles");

  // unusable altitude carries zero altitude and zero weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !altitude_valid_o |-> altitude_mm_o == 16'd0 && blend_weight_o == 16'd0)
    else $error("invalid altitude not zeroed");

  // fresh reading implies usable altitude and no reject
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fresh_ok_o |-> altitude_valid_o && reject_reason_o == RejNone)
    else $error("fresh reading inconsistent");

  // weight never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> blend_weight_o <= OneQ15)
    else $error("blend weight above one");

endmodule

bind range_reading_plausibility_gate_unit rrpg_checker u_rrpg_checker (.*);
